// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the frame allocator.
// Depends on nothing; include it with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bfa_pkg.sv =====
// Package for the buffer frame allocator: field widths, defaults, codes and
// the command/status bundles between controller and datapath. No dependencies.
`default_nettype none

package bfa_pkg;

    // Fixed field widths of the item channels.
    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int FREE_W   = 5;

    // Defaults for the top-level parameters.
    localparam int FRAMES_DEF      = 16;
    localparam int HANDLE_BITS_DEF = 32;

    // Request codes.
    typedef enum logic [FUNC_W-1:0] {
        F_NEW_PAGE  = 3'd0,
        F_SET_PIN   = 3'd1,
        F_RESET_PIN = 3'd2,
        F_GET_PIN   = 3'd3,
        F_INIT      = 3'd4
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming item and restart the scan
        logic scan;     // advance the frame scan by one entry
        logic resolve;  // latch the scan outcome
        logic commit;   // update the frame table and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stop;     // scan has found its frame, reached the end, or is not needed
        logic out_free; // result register can take a new item this cycle
    } t_sts;

endpackage

`default_nettype wire

// ===== design/buffer_frame_allocator_with_pinning.sv =====
// Buffer frame allocator with pinning: top level joining controller and
// datapath. Depends on bfa_pkg, bfa_ctrl and bfa_dp.
//
// Use: requests arrive on the input channel (i_in_valid / o_in_stall) as a
// function code, a handle and a use-current flag. Each request yields exactly
// one result item on the output channel (o_out_valid / i_out_stall) with a
// status, a handle, a frame index, the pin mark and the free frame count.
// The block works on one item at a time; o_in_stall is high from acceptance
// until the result is loaded into the output register.
// Scan: a new-page request steps through the free flags and stops at the
// lowest free frame or the last one; a pin request reads the handle memory
// through its single read port and stops at the first matching frame or the
// last one. Both scans take one frame per cycle; initialize and unused codes
// do not scan.
// Reset clears the valid and pin flags, the handle counter and the output
// valid and marks all frames free; handle entries only match for valid frames.
// When the receiver stalls, the result is held in the output register; the
// next item is still accepted and scanned, and waits only at commit.
`default_nettype none

module buffer_frame_allocator_with_pinning #(
    parameter int FRAMES      = bfa_pkg::FRAMES_DEF,
    parameter int HANDLE_BITS = bfa_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [bfa_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [bfa_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic                           i_use_current,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]        o_status,
    output logic [bfa_pkg::HANDLE_W-1:0]        o_result_handle,
    output logic [bfa_pkg::FIDX_W-1:0]          o_frame_index,
    output logic                                o_pinned,
    output logic [bfa_pkg::FREE_W-1:0]          o_free_pages
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Frame table and result register.
    bfa_dp #(
        .FRAMES      (FRAMES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_handle        (i_handle),
        .i_use_current   (i_use_current),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_result_handle (o_result_handle),
        .o_frame_index   (o_frame_index),
        .o_pinned        (o_pinned),
        .o_free_pages    (o_free_pages)
    );

endmodule

`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// Controller state machine of the frame allocator: sequences load, scan,
// resolve and commit. Depends on bfa_pkg.
`default_nettype none

module bfa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import bfa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.stop) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath and the input stall.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan    = !i_sts.stop;
                o_cmd.resolve = i_sts.stop;
            end
            S_DONE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bfa_dp.sv =====
// Datapath of the frame allocator: frame flags, handle memory, handle counter,
// scan index and result register. Depends on bfa_pkg.
`default_nettype none

module bfa_dp #(
    parameter int FRAMES      = bfa_pkg::FRAMES_DEF,
    parameter int HANDLE_BITS = bfa_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bfa_pkg::t_cmd                  i_cmd,
    output bfa_pkg::t_sts                       o_sts,
    input  wire logic [bfa_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [bfa_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic                           i_use_current,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic [bfa_pkg::STATUS_W-1:0]        o_status,
    output logic [bfa_pkg::HANDLE_W-1:0]        o_result_handle,
    output logic [bfa_pkg::FIDX_W-1:0]          o_frame_index,
    output logic                                o_pinned,
    output logic [bfa_pkg::FREE_W-1:0]          o_free_pages
);
    import bfa_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    // Handle store: one entry per frame, read one entry a cycle during a scan.
    logic [HANDLE_BITS-1:0] mem_handle [FRAMES];
    logic [HANDLE_BITS-1:0] r_rd_data;
    logic                   mem_we;

    // Item and scan registers.
    t_func                  r_func,    n_func;
    logic [HANDLE_BITS-1:0] r_key,     n_key;
    logic [IW-1:0]          r_idx,     n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_hit,     n_hit;
    logic [IW-1:0]          r_fidx,    n_fidx;

    // Frame table state.
    logic [FRAMES-1:0]      r_valid,    n_valid;
    logic [FRAMES-1:0]      r_pinned,   n_pinned;
    logic [FRAMES-1:0]      r_free,     n_free;
    logic [HANDLE_BITS-1:0] r_counter,  n_counter;
    logic [CW-1:0]          r_free_cnt, n_free_cnt;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    t_status                r_o_status,  n_o_status;
    logic [HANDLE_W-1:0]    r_o_handle,  n_o_handle;
    logic [FIDX_W-1:0]      r_o_fidx,    n_o_fidx;
    logic                   r_o_pinned,  n_o_pinned;
    logic [FREE_W-1:0]      r_o_free,    n_o_free;

    logic is_new;
    logic is_pin;
    logic found;
    logic last;

    // Scan outcome: the free scan looks at the flag of the current index, the
    // handle scan compares the entry read in the previous cycle.
    always_comb begin
        is_new = (r_func == F_NEW_PAGE);
        is_pin = (r_func == F_SET_PIN) || (r_func == F_RESET_PIN) || (r_func == F_GET_PIN);
        if (is_new) begin
            found = r_free[r_idx];
            last  = (r_idx == LAST_IDX);
        end else begin
            found = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_key);
            last  = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        end
        o_sts.stop     = (!is_new && !is_pin) || found || last;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // A new handle is written when a new page request succeeds.
    assign mem_we = i_cmd.commit && is_new && r_hit && !(&r_counter);

    // Next-state logic of all registers.
    always_comb begin
        n_func      = r_func;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_fidx      = r_fidx;
        n_valid     = r_valid;
        n_pinned    = r_pinned;
        n_free      = r_free;
        n_counter   = r_counter;
        n_free_cnt  = r_free_cnt;
        n_o_status  = r_o_status;
        n_o_handle  = r_o_handle;
        n_o_fidx    = r_o_fidx;
        n_o_pinned  = r_o_pinned;
        n_o_free    = r_o_free;
        n_out_valid = r_out_valid && i_out_stall;

        // Capture the item; the lookup key is the latest handle on request.
        if (i_cmd.load) begin
            n_func    = t_func'(i_func);
            n_key     = i_use_current ? r_counter : HANDLE_BITS'(i_handle);
            n_idx     = '0;
            n_cmp_vld = 1'b0;
        end

        // Step the scan; the index holds at the last frame.
        if (i_cmd.scan) begin
            if (r_idx != LAST_IDX) begin
                n_idx = r_idx + 1'b1;
            end
            n_cmp_vld = !is_new;
            n_cmp_idx = r_idx;
        end

        // Latch the frame the scan stopped on.
        if (i_cmd.resolve) begin
            n_hit     = found;
            n_fidx    = is_new ? r_idx : r_cmp_idx;
            n_cmp_vld = 1'b0;
        end

        // Apply the operation and build the result item.
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            n_o_status  = ST_OK;
            n_o_handle  = '0;
            n_o_fidx    = '0;
            n_o_pinned  = 1'b0;
            case (r_func)
                F_NEW_PAGE: begin
                    if (!r_hit) begin
                        n_o_status = ST_NO_FREE;
                    end else if (&r_counter) begin
                        n_o_status = ST_EXHAUSTED;
                    end else begin
                        n_counter        = r_counter + 1'b1;
                        n_valid[r_fidx]  = 1'b1;
                        n_pinned[r_fidx] = 1'b0;
                        n_o_handle       = HANDLE_W'(n_counter);
                        n_o_fidx         = FIDX_W'(r_fidx);
                    end
                end
                F_SET_PIN, F_RESET_PIN, F_GET_PIN: begin
                    n_o_handle = HANDLE_W'(r_key);
                    if (!r_hit) begin
                        n_o_status = ST_NOT_FOUND;
                    end else begin
                        if (r_func == F_SET_PIN) begin
                            n_pinned[r_fidx] = 1'b1;
                            if (r_free[r_fidx]) begin
                                n_free[r_fidx] = 1'b0;
                                n_free_cnt     = r_free_cnt - 1'b1;
                            end
                        end else if (r_func == F_RESET_PIN) begin
                            n_pinned[r_fidx] = 1'b0;
                            if (!r_free[r_fidx]) begin
                                n_free[r_fidx] = 1'b1;
                                n_free_cnt     = r_free_cnt + 1'b1;
                            end
                        end
                        n_o_fidx   = FIDX_W'(r_fidx);
                        n_o_pinned = n_pinned[r_fidx];
                    end
                end
                F_INIT: begin
                    n_valid    = '0;
                    n_pinned   = '0;
                    n_free     = '1;
                    n_counter  = '0;
                    n_free_cnt = CW'(FRAMES);
                end
                default: begin
                    n_o_status = ST_OK;
                end
            endcase
            n_o_free = FREE_W'(n_free_cnt);
        end
    end

    // Control and table registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pinned    <= '0;
            r_free      <= '1;
            r_counter   <= '0;
            r_free_cnt  <= CW'(FRAMES);
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_pinned    <= n_pinned;
            r_free      <= n_free;
            r_counter   <= n_counter;
            r_free_cnt  <= n_free_cnt;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_fidx     <= n_fidx;
        r_o_status <= n_o_status;
        r_o_handle <= n_o_handle;
        r_o_fidx   <= n_o_fidx;
        r_o_pinned <= n_o_pinned;
        r_o_free   <= n_o_free;
    end

    // Handle memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_handle[r_fidx] <= n_counter;
        end
        r_rd_data <= mem_handle[r_idx];
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_result_handle = r_o_handle;
    assign o_frame_index   = r_o_fidx;
    assign o_pinned        = r_o_pinned;
    assign o_free_pages    = r_o_free;

endmodule

`default_nettype wire

// ===== design/bfa_checker.sv =====
// Port-level checker for the frame allocator and its bind to the top level.
// Depends on bfa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bfa_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [bfa_pkg::STATUS_W-1:0]   o_status,
    input wire logic [bfa_pkg::HANDLE_W-1:0]   o_result_handle,
    input wire logic [bfa_pkg::FIDX_W-1:0]     o_frame_index,
    input wire logic                           o_pinned
);
    import bfa_pkg::*;

    // One item at a time: an accepted item stalls the input in the next cycle.
    `BFA_ASSERT(a_accept_stalls, i_clk, i_rst_n,
        i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after accept")

    // A failed allocation reports no handle, frame or pin mark.
    `BFA_ASSERT(a_nofree_zero, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_NO_FREE || o_status == ST_EXHAUSTED) |->
        o_result_handle == '0 && o_frame_index == '0 && !o_pinned,
        "failed allocation carries payload")

    // A lookup miss reports no frame and no pin mark.
    `BFA_ASSERT(a_miss_zero, i_clk, i_rst_n,
        o_out_valid && o_status == ST_NOT_FOUND |-> o_frame_index == '0 && !o_pinned,
        "lookup miss carries frame")

    // A stalled result stays valid and its handle unchanged.
    `BFA_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_handle),
        "stalled result changed")

    // No result is presented in the cycle after a reset cycle.
    `BFA_ASSERT_ALWAYS(a_reset_clear, i_clk,
        !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind buffer_frame_allocator_with_pinning bfa_checker u_bfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_result_handle (o_result_handle),
    .o_frame_index   (o_frame_index),
    .o_pinned        (o_pinned)
);

`default_nettype wire
